/* hw/rtl/sh128_pkg.sv */
package sh128_pkg;

    // Input command codes, carried on s_tuser
    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_MSG    = 2'd1,
        CMD_LAST   = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FOLD,
        OP_MIX_V3,
        OP_HALF,
        OP_MIX_V0,
        OP_TAG,
        OP_H0,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fin;      // message word includes the length byte
        logic half_b;   // second half of a SipRound
    } dp_cmd_t;

    typedef struct packed {
        logic in_message;
        logic word_full;  // next message byte completes a 64-bit word
    } dp_stat_t;

    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
    localparam logic [63:0] TAG_FIRST  = 64'h0000_0000_0000_00ee;
    localparam logic [63:0] TAG_SECOND = 64'h0000_0000_0000_00dd;

    localparam logic [31:0] FOLD_INIT0 = 32'h736f_6d65;
    localparam logic [31:0] FOLD_INIT1 = 32'h646f_7261;
    localparam logic [31:0] FOLD_INIT2 = 32'h6c79_6765;
    localparam logic [31:0] FOLD_INIT3 = 32'h7465_6462;

    localparam logic [63:0] LANE_C0 = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] LANE_C1 = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] LANE_C2 = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] LANE_C3 = 64'h7465_6462_7974_6573;

endpackage

/* hw/rtl/sh128_ctrl.sv */
module sh128_ctrl
    import sh128_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [1:0] s_tuser,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  dp_cmd,
    input  dp_stat_t dp_stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ABS_XOR,
        ST_ABS_RND,
        ST_ABS_END,
        ST_FIN_XOR,
        ST_FIN_RND1,
        ST_FIN_TAG,
        ST_FIN_RND2,
        ST_FIN_H0,
        ST_FIN_RND3,
        ST_FIN_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] half_cnt_reg, half_cnt_next;
    logic       fin_pend_reg, fin_pend_next;
    logic       m_valid_reg, m_valid_next;
    cmd_t       in_cmd;

    assign in_cmd   = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        half_cnt_next = '0;
        fin_pend_next = fin_pend_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        dp_cmd.op     = OP_NONE;
        dp_cmd.fin    = 1'b0;
        dp_cmd.half_b = half_cnt_reg[0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_cmd)
                        CMD_KEY: begin
                            // key bytes are dropped once a message has begun
                            if (!dp_stat.in_message) begin
                                dp_cmd.op  = OP_ACCEPT;
                                state_next = ST_FOLD;
                            end
                        end
                        CMD_MSG: begin
                            dp_cmd.op     = OP_ACCEPT;
                            fin_pend_next = 1'b0;
                            if (dp_stat.word_full) begin
                                state_next = ST_ABS_XOR;
                            end
                        end
                        CMD_LAST: begin
                            dp_cmd.op = OP_ACCEPT;
                            if (dp_stat.word_full) begin
                                fin_pend_next = 1'b1;
                                state_next    = ST_ABS_XOR;
                            end else begin
                                state_next = ST_FIN_XOR;
                            end
                        end
                        CMD_FINISH: begin
                            dp_cmd.op  = OP_ACCEPT;
                            state_next = ST_FIN_XOR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FOLD: begin
                dp_cmd.op  = OP_FOLD;
                state_next = ST_IDLE;
            end
            ST_ABS_XOR: begin
                dp_cmd.op  = OP_MIX_V3;
                state_next = ST_ABS_RND;
            end
            ST_ABS_RND: begin
                dp_cmd.op     = OP_HALF;
                half_cnt_next = half_cnt_reg + 3'd1;
                if (half_cnt_reg == 3'd3) begin
                    state_next = ST_ABS_END;
                end
            end
            ST_ABS_END: begin
                dp_cmd.op     = OP_MIX_V0;
                fin_pend_next = 1'b0;
                state_next    = fin_pend_reg ? ST_FIN_XOR : ST_IDLE;
            end
            ST_FIN_XOR: begin
                dp_cmd.op  = OP_MIX_V3;
                dp_cmd.fin = 1'b1;
                state_next = ST_FIN_RND1;
            end
            ST_FIN_RND1: begin
                dp_cmd.op     = OP_HALF;
                half_cnt_next = half_cnt_reg + 3'd1;
                if (half_cnt_reg == 3'd3) begin
                    state_next = ST_FIN_TAG;
                end
            end
            ST_FIN_TAG: begin
                dp_cmd.op  = OP_TAG;
                dp_cmd.fin = 1'b1;
                state_next = ST_FIN_RND2;
            end
            ST_FIN_RND2: begin
                dp_cmd.op     = OP_HALF;
                half_cnt_next = half_cnt_reg + 3'd1;
                if (half_cnt_reg == 3'd7) begin
                    state_next = ST_FIN_H0;
                end
            end
            ST_FIN_H0: begin
                dp_cmd.op  = OP_H0;
                state_next = ST_FIN_RND3;
            end
            ST_FIN_RND3: begin
                dp_cmd.op     = OP_HALF;
                half_cnt_next = half_cnt_reg + 3'd1;
                if (half_cnt_reg == 3'd7) begin
                    state_next = ST_FIN_OUT;
                end
            end
            ST_FIN_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    dp_cmd.op    = OP_DONE;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            half_cnt_reg <= '0;
            fin_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            half_cnt_reg <= half_cnt_next;
            fin_pend_reg <= fin_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

/* hw/rtl/sh128_dp.sv */
module sh128_dp
    import sh128_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   s_tdata,
    input  logic [1:0]   s_tuser,
    output logic [127:0] m_tdata,
    input  dp_cmd_t      dp_cmd,
    output dp_stat_t     dp_stat
);

    typedef logic [3:0][63:0] lanes_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic lanes_t half_a(input lanes_t v);
        lanes_t     r;
        logic [63:0] s0, s2;
        s0   = v[0] + v[1];
        s2   = v[2] + v[3];
        r[1] = rotl64(v[1], 13) ^ s0;
        r[3] = rotl64(v[3], 16) ^ s2;
        r[0] = rotl64(s0, 32);
        r[2] = s2;
        return r;
    endfunction

    function automatic lanes_t half_b(input lanes_t v);
        lanes_t     r;
        logic [63:0] s0, s2;
        s2   = v[2] + v[1];
        s0   = v[0] + v[3];
        r[1] = rotl64(v[1], 17) ^ s2;
        r[3] = rotl64(v[3], 21) ^ s0;
        r[2] = rotl64(s2, 32);
        r[0] = s0;
        return r;
    endfunction

    logic [31:0]  fold_reg [4];
    logic [31:0]  fold_next [4];
    logic [1:0]   slot_reg, slot_next;
    logic         in_msg_reg, in_msg_next;
    logic [63:0]  partial_reg, partial_next;
    logic [7:0]   count_reg, count_next;
    logic [7:0]   key_byte_reg, key_byte_next;
    lanes_t       lanes_reg, lanes_next;
    logic [63:0]  h0_reg, h0_next;
    logic [127:0] digest_reg, digest_next;

    logic [63:0]  msg_word;
    logic [63:0]  lane_xor;
    logic [63:0]  k0, k1;
    logic [31:0]  fold_sel;
    cmd_t         in_cmd;

    assign in_cmd   = cmd_t'(s_tuser);
    assign fold_sel = fold_reg[slot_reg];
    assign k0       = {fold_reg[0], fold_reg[1]};
    assign k1       = {fold_reg[2], fold_reg[3]};
    assign msg_word = dp_cmd.fin ? (partial_reg | {count_reg, 56'd0}) : partial_reg;
    assign lane_xor = lanes_reg[0] ^ lanes_reg[1] ^ lanes_reg[2] ^ lanes_reg[3];

    assign dp_stat.in_message = in_msg_reg;
    assign dp_stat.word_full  = (count_reg[2:0] == 3'd7);
    assign m_tdata            = digest_reg;

    always_comb begin
        fold_next     = fold_reg;
        slot_next     = slot_reg;
        in_msg_next   = in_msg_reg;
        partial_next  = partial_reg;
        count_next    = count_reg;
        key_byte_next = key_byte_reg;
        lanes_next    = lanes_reg;
        h0_next       = h0_reg;
        digest_next   = digest_reg;

        unique case (dp_cmd.op)
            OP_NONE: begin
            end
            OP_ACCEPT: begin
                if (in_cmd == CMD_KEY) begin
                    key_byte_next = s_tdata;
                end else begin
                    if (!in_msg_reg) begin
                        lanes_next[0] = k0 ^ LANE_C0;
                        lanes_next[1] = k1 ^ LANE_C1 ^ TAG_FIRST;
                        lanes_next[2] = k0 ^ LANE_C2;
                        lanes_next[3] = k1 ^ LANE_C3;
                        in_msg_next   = 1'b1;
                    end
                    if (in_cmd != CMD_FINISH) begin
                        partial_next[{count_reg[2:0], 3'b000} +: 8] = s_tdata;
                        count_next = count_reg + 8'd1;
                    end
                end
            end
            OP_FOLD: begin
                fold_next[slot_reg] = 32'((fold_sel ^ {24'd0, key_byte_reg}) * FNV_PRIME);
                slot_next           = slot_reg + 2'd1;
            end
            OP_MIX_V3: begin
                lanes_next[3] = lanes_reg[3] ^ msg_word;
            end
            OP_HALF: begin
                lanes_next = dp_cmd.half_b ? half_b(lanes_reg) : half_a(lanes_reg);
            end
            OP_MIX_V0: begin
                lanes_next[0] = lanes_reg[0] ^ msg_word;
                partial_next  = '0;
            end
            OP_TAG: begin
                lanes_next[0] = lanes_reg[0] ^ msg_word;
                lanes_next[2] = lanes_reg[2] ^ TAG_FIRST;
            end
            OP_H0: begin
                h0_next       = lane_xor;
                lanes_next[1] = lanes_reg[1] ^ TAG_SECOND;
            end
            OP_DONE: begin
                // halves swapped: low 32 bits lead in each output word
                digest_next  = {lane_xor[31:0], lane_xor[63:32], h0_reg[31:0], h0_reg[63:32]};
                fold_next[0] = FOLD_INIT0;
                fold_next[1] = FOLD_INIT1;
                fold_next[2] = FOLD_INIT2;
                fold_next[3] = FOLD_INIT3;
                slot_next    = '0;
                in_msg_next  = 1'b0;
                partial_next = '0;
                count_next   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg[0] <= FOLD_INIT0;
            fold_reg[1] <= FOLD_INIT1;
            fold_reg[2] <= FOLD_INIT2;
            fold_reg[3] <= FOLD_INIT3;
            slot_reg    <= '0;
            in_msg_reg  <= 1'b0;
            partial_reg <= '0;
            count_reg   <= '0;
        end else begin
            fold_reg    <= fold_next;
            slot_reg    <= slot_next;
            in_msg_reg  <= in_msg_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_byte_reg <= key_byte_next;
        lanes_reg    <= lanes_next;
        h0_reg       <= h0_next;
        digest_reg   <= digest_next;
    end

endmodule

/* hw/rtl/siphash128_keyed_hash.sv */
// Keyed 128-bit hash over a byte stream (SipHash-2-4, 128-bit output). Send key
// bytes first (tuser 0), then message bytes (tuser 1), closing with tuser 2 on the
// last byte, or tuser 3 to finish without a new byte (an empty message if none
// began). A key byte then runs a fold state (one FNV fold multiply), and each
// eighth message byte adds the word absorb through the
// shared half-round unit, which does one half SipRound per cycle. Finishing runs
// the finalization rounds (after an absorb if the last byte completes a word) before the digest is loaded;
// it then waits in the output register, and key bytes for the next digest are
// taken meanwhile. After each digest the key fold returns to its initial words.
module siphash128_keyed_hash
    import sh128_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data
    input  logic [1:0]   s_tuser,   // [1:0] cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] digest_first, [127:64] digest_second
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    sh128_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    sh128_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

endmodule

/* hw/rtl/sh128_checker.sv */
module sh128_checker
    import sh128_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a stalled digest holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("digest changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // input is closed right after a finishing transfer while the digest is computed
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_LAST || s_tuser == CMD_FINISH) |=> !s_tready)
        else $error("input open right after a finish transfer");

    // key and plain message bytes never produce a digest
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid && (s_tuser == CMD_KEY || s_tuser == CMD_MSG)
        |=> !m_tvalid)
        else $error("digest without a finish");

    a_data_known: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("digest appeared without a finish in progress");

endmodule

bind siphash128_keyed_hash sh128_checker u_sh128_checker (.*);
